[hw/rtl/alfr_pkg.sv]
// shared types and constants for the assistance-level frame responder
// no dependencies; imported by every module of the block

package alfr_pkg;

	localparam int NUM_LEVELS = 3;
	localparam int LEVEL_W    = 2;
	localparam int ID_W       = 11;
	localparam int IDX_W      = 3;

	localparam logic [ID_W-1:0] ID_LEVEL = 11'h454;
	localparam logic [ID_W-1:0] ID_SPEED = 11'h201;
	localparam logic [ID_W-1:0] ID_PACK1 = 11'h402;
	localparam logic [ID_W-1:0] ID_PACK2 = 11'h403;

	localparam logic [7:0] BTN_PLUS      = 8'h0A;
	localparam logic [7:0] BTN_MINUS     = 8'h0E;
	localparam logic [7:0] WALK_ON_CODE  = 8'hA5;
	localparam logic [7:0] WALK_OFF_CODE = 8'h5A;

	localparam logic [LEVEL_W-1:0] LEVEL_TOP = 2'd2;

	localparam logic [1:0] PACK_NONE = 2'd0;
	localparam logic [1:0] PACK_ONE  = 2'd1;
	localparam logic [1:0] PACK_TWO  = 2'd2;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 72;

	typedef enum logic [IDX_W-1:0] {
		REG_LEVEL0_MEAN = 3'd0,
		REG_LEVEL0_MAX  = 3'd1,
		REG_LEVEL1_MEAN = 3'd2,
		REG_LEVEL1_MAX  = 3'd3,
		REG_LEVEL2_MEAN = 3'd4,
		REG_LEVEL2_MAX  = 3'd5,
		REG_INIT_LEVEL  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [ID_W-1:0] frame_id;
		logic [7:0]      byte0;
		logic [7:0]      byte1;
		logic [7:0]      byte4;
		logic [7:0]      byte5;
		logic [7:0]      byte6;
		logic [7:0]      byte7;
	} item_t;

	typedef struct packed {
		logic [NUM_LEVELS-1:0][7:0] mean;
		logic [NUM_LEVELS-1:0][7:0] max;
	} cfg_regs_t;

	typedef struct packed {
		logic               valid;
		logic [LEVEL_W-1:0] level;
	} level_load_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [7:0]         mean_byte;
		logic [7:0]         limit_byte;
		logic [7:0]         walk_byte;
		logic [1:0]         alive_tone;
		logic [1:0]         change_tone;
		logic               idle_reset;
		logic [1:0]         pack_update;
		logic [7:0]         charge_percent;
		logic [31:0]        charge_mwh;
	} result_t;

endpackage

[hw/rtl/assist_level_frame_responder.sv]
// top level of the assistance-level frame responder: stream ports, input and
// result registers; depends on alfr_pkg, alfr_cfg and alfr_core
//
//   channel   direction  handshake                 payload
//   s_*       in         s_tvalid / s_tready        tuser frame_id, tdata bytes 0,1,4..7
//   m_*       out        m_tvalid / m_tready        tuser pack_update, tdata status fields
//   cfg_*     in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one beat per cycle sustained while m_tready is high; each input beat passes through
// the input register, then decode/update logic into the result register
// arst_n clears both valid flags and the level/transition/walk state, config to defaults
// a stalled result is held while the input register refills; s_tready drops only
// when both registers are full and m_tready is low
// cfg_ready is always high; config is to be written only while the block is idle (the block does not enforce this)

module assist_level_frame_responder
	import alfr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input frames
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // byte0, byte1, byte4, byte5, byte6, byte7
	input  logic [ID_W-1:0]       s_tuser,   // frame_id
	// status results
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // level, mean_byte, limit_byte, walk_byte,
	                                         // alive_tone, change_tone, idle_reset,
	                                         // charge_percent, charge_mwh, zero pad
	output logic [1:0]            m_tuser,   // pack_update
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [7:0]            cfg_data
);

	logic        valid_s1;
	item_t       item_s1;
	logic        valid_s2;
	result_t     result_s2;
	result_t     result;
	logic        advance;
	cfg_regs_t   regs;
	level_load_t load;

	// item moves from the input register into the result register when the
	// result register is empty or its beat is taken this cycle
	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.frame_id <= s_tuser;
			item_s1.byte0    <= s_tdata[7:0];
			item_s1.byte1    <= s_tdata[15:8];
			item_s1.byte4    <= s_tdata[23:16];
			item_s1.byte5    <= s_tdata[31:24];
			item_s1.byte6    <= s_tdata[39:32];
			item_s1.byte7    <= s_tdata[47:40];
		end
	end

	alfr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs     (regs),
		.load     (load)
	);

	alfr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.regs    (regs),
		.load    (load),
		.result  (result)
	);

	// result register doubles as the output skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = result_s2.pack_update;
	assign m_tdata  = {1'b0,
	                   result_s2.charge_mwh,
	                   result_s2.charge_percent,
	                   result_s2.idle_reset,
	                   result_s2.change_tone,
	                   result_s2.alive_tone,
	                   result_s2.walk_byte,
	                   result_s2.limit_byte,
	                   result_s2.mean_byte,
	                   result_s2.level};

endmodule

[hw/rtl/alfr_cfg.sv]
// configuration register file: level mean/max bytes and the initial level load
// depends on alfr_pkg

module alfr_cfg
	import alfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [7:0]        wr_data,
	output cfg_regs_t         regs,
	output level_load_t       load
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.mean[0] <= 8'd30;
			regs_q.max[0]  <= 8'd35;
			regs_q.mean[1] <= 8'd40;
			regs_q.max[1]  <= 8'd90;
			regs_q.mean[2] <= 8'd95;
			regs_q.max[2]  <= 8'd100;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LEVEL0_MEAN: regs_q.mean[0] <= wr_data;
				REG_LEVEL0_MAX:  regs_q.max[0]  <= wr_data;
				REG_LEVEL1_MEAN: regs_q.mean[1] <= wr_data;
				REG_LEVEL1_MAX:  regs_q.max[1]  <= wr_data;
				REG_LEVEL2_MEAN: regs_q.mean[2] <= wr_data;
				REG_LEVEL2_MAX:  regs_q.max[2]  <= wr_data;
				default: ;
			endcase
		end
	end

	// initial level goes straight into the level state; code 3 means level 2
	always_comb begin
		load.valid = wr_en && (wr_index == REG_INIT_LEVEL);
		load.level = (wr_data[LEVEL_W-1:0] > LEVEL_TOP) ? LEVEL_TOP : wr_data[LEVEL_W-1:0];
	end

	assign regs = regs_q;

endmodule

[hw/rtl/alfr_core.sv]
// level, transition and walk state with the per-frame decode and result logic
// depends on alfr_pkg

module alfr_core
	import alfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  item_t       item,
	input  cfg_regs_t   regs,
	input  level_load_t load,
	output result_t     result
);

	logic [LEVEL_W-1:0]    level_q, level_d;
	logic                  alive_q, alive_d;
	logic                  trans_q, trans_d;
	logic [7:0]            held_q, held_d;
	logic [NUM_LEVELS-1:0] walk_q, walk_d;
	logic [NUM_LEVELS-1:0] match;
	logic [LEVEL_W-1:0]    match_level;
	logic                  is_level, is_speed, is_pack1, is_pack2, is_button;
	logic [1:0]            alive_tone, change_tone;

	always_comb begin
		is_level  = item.frame_id == ID_LEVEL;
		is_speed  = item.frame_id == ID_SPEED;
		is_pack1  = item.frame_id == ID_PACK1;
		is_pack2  = item.frame_id == ID_PACK2;
		is_button = (item.byte6 == BTN_PLUS) || (item.byte6 == BTN_MINUS);
		for (int i = 0; i < NUM_LEVELS; i++) begin
			match[i] = regs.mean[i] == item.byte4;
		end
		// lowest matching level wins
		if (match[0]) begin
			match_level = 2'd0;
		end else if (match[1]) begin
			match_level = 2'd1;
		end else begin
			match_level = LEVEL_TOP;
		end
	end

	always_comb begin
		level_d     = level_q;
		alive_d     = alive_q;
		trans_d     = trans_q;
		held_d      = held_q;
		walk_d      = walk_q;
		alive_tone  = 2'd0;
		change_tone = 2'd0;
		if (is_level) begin
			if (!alive_q) begin
				alive_d    = 1'b1;
				alive_tone = level_q + 2'd1;
			end
			if (is_button) begin
				if (trans_q) begin
					trans_d     = 1'b0;
					change_tone = level_q + 2'd1;
				end else if (|match) begin
					level_d = match_level;
					trans_d = 1'b1;
					held_d  = item.byte6;
				end
			end
			walk_d[level_d] = item.byte1 == WALK_ON_CODE;
		end
	end

	always_comb begin
		result.level          = level_d;
		result.mean_byte      = regs.mean[level_d];
		result.limit_byte     = trans_d ? held_d : regs.max[level_d];
		result.walk_byte      = walk_d[level_d] ? WALK_ON_CODE : WALK_OFF_CODE;
		result.alive_tone     = alive_tone;
		result.change_tone    = change_tone;
		result.idle_reset     = is_speed && ((item.byte0 != 8'd0) || (item.byte1 != 8'd0));
		result.pack_update    = is_pack1 ? PACK_ONE : (is_pack2 ? PACK_TWO : PACK_NONE);
		result.charge_percent = (is_pack1 || is_pack2) ? item.byte0 : 8'd0;
		result.charge_mwh     = (is_pack1 || is_pack2) ?
			{item.byte7, item.byte6, item.byte5, item.byte4} : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 2'd0;
			alive_q <= 1'b0;
			trans_q <= 1'b0;
			held_q  <= 8'd0;
			walk_q  <= '0;
		end else if (load.valid) begin
			level_q <= load.level;
		end else if (advance) begin
			level_q <= level_d;
			alive_q <= alive_d;
			trans_q <= trans_d;
			held_q  <= held_d;
			walk_q  <= walk_d;
		end
	end

endmodule

[hw/rtl/alfr_checker.sv]
// port-level checks on the result stream of the frame responder, bound to the top
// depends on alfr_pkg and assist_level_frame_responder

module alfr_checker
	import alfr_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [1:0]            m_tuser
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result beat changed");

	// level field never shows the unused code
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("level out of range");

	// walk byte is one of the two codes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[25:18] == WALK_ON_CODE) || (m_tdata[25:18] == WALK_OFF_CODE))
		else $error("bad walk byte");

	// alive tone comes only before any transition can end
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[27:26] == 2'd0) || (m_tdata[29:28] == 2'd0))
		else $error("alive and change tone together");

	// charge fields are zero without a pack report
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == PACK_NONE) |-> m_tdata[71:31] == '0)
		else $error("charge fields set without pack report");

endmodule

bind assist_level_frame_responder alfr_checker u_alfr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
